// File: sv/linear_probe_hash_table_defines.svh
// Assertion macros used by the checker file.
`ifndef LINEAR_PROBE_HASH_TABLE_DEFINES_SVH
`define LINEAR_PROBE_HASH_TABLE_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define LPHT_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define LPHT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: sv/lpht_pkg.sv
// ----------------------------------------------------------------------------
// lpht_pkg
// Constants, codes and control/status types of the linear-probe hash table.
// ----------------------------------------------------------------------------
package lpht_pkg;

    localparam int TABLE_DEPTH = 32;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int KEY_W       = 8;
    localparam int WORD_W      = 64;
    localparam int OP_W        = 2;
    localparam int ST_W        = 2;
    localparam int POS_W       = 5;
    localparam int CFG_W       = 6;
    localparam int DIV_CNT_W   = $clog2(KEY_W + 1);

    localparam logic [KEY_W-1:0] HOME_OFFSET = 8'd97;
    localparam logic [CFG_W-1:0] SIZE_RESET  = 6'd32;

    // operations
    localparam logic [OP_W-1:0] OP_INS_KEEP    = 2'd0;
    localparam logic [OP_W-1:0] OP_INS_REPLACE = 2'd1;
    localparam logic [OP_W-1:0] OP_FIND        = 2'd2;

    // result status
    localparam logic [ST_W-1:0] ST_INSERTED  = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL      = 2'd1;
    localparam logic [ST_W-1:0] ST_FOUND     = 2'd2;
    localparam logic [ST_W-1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic            load;
        logic            div_step;
        logic            probe_init;
        logic            probe_adv;
        logic            wr_new;
        logic            wr_old;
        logic            swap;
        logic            res_set;
        logic [ST_W-1:0] res_status;
        logic            res_pos_home;
        logic            res_pos_zero;
        logic            out_load;
    } t_cmd;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            div_done;
        logic            full;
        logic            empty;
        logic            hit;
        logic            first;
        logic            last;
        logic            out_free;
    } t_stat;

endpackage

// File: sv/linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// linear_probe_hash_table
// Open-addressed word/meaning dictionary with linear probing.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one beat per operation, tuser = operation (insert keep,
//   insert replace, find), tdata = hash key, word, meaning.
//   Output stream: one beat per operation, tuser = status, tdata = slot.
//   Config channel: writes the slot count in use; write it only while no
//   operation is in flight.
// Steps per operation: the capture of the beat, the bit-serial remainder unit
//   for the home slot (8 steps and a done check), dispatch, the probe scan
//   at one slot per cycle (up to n slots, the swap of an insert with
//   replacement included), then the hand-off into the output register, which
//   waits until that register is free. The block takes one operation at a
//   time: the next beat is taken the cycle after the hand-off.
// Reset: all slots empty, slot count 32, output stream idle.
// Stall: a held output beat does not block the next input beat; the block
//   waits with its next result until the output register is free.
// ----------------------------------------------------------------------------
module linear_probe_hash_table (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // input stream
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [135:0] i_s_axis_tdata,  // hash_key[7:0], word[71:8], meaning_text[135:72]
    input  logic [1:0]   i_s_axis_tuser,  // operation[1:0]
    // result stream
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    output logic [7:0]   o_m_axis_tdata,  // position[4:0], zero fill [7:5]
    output logic [1:0]   o_m_axis_tuser,  // status[1:0]
    // configuration
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [5:0]   i_cfg_data
);

    lpht_pkg::t_cmd  w_cmd;
    lpht_pkg::t_stat w_stat;
    logic [lpht_pkg::POS_W-1:0] w_pos;

    assign o_cfg_ready = 1'b1;

    lpht_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_s_axis_tvalid),
        .o_in_ready (o_s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    lpht_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .o_stat         (w_stat),
        .i_operation    (i_s_axis_tuser),
        .i_hash_key     (i_s_axis_tdata[7:0]),
        .i_word         (i_s_axis_tdata[71:8]),
        .i_meaning_text (i_s_axis_tdata[135:72]),
        .i_cfg_valid    (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_out_ready    (i_m_axis_tready),
        .o_out_valid    (o_m_axis_tvalid),
        .o_out_status   (o_m_axis_tuser),
        .o_out_pos      (w_pos)
    );

    assign o_m_axis_tdata = {3'b000, w_pos};

endmodule

// File: sv/lpht_ctrl.sv
// ----------------------------------------------------------------------------
// lpht_ctrl
// Sequencer: remainder steps, dispatch, probe scans and result hand-off.
// ----------------------------------------------------------------------------
module lpht_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    input  lpht_pkg::t_stat i_stat,
    output lpht_pkg::t_cmd  o_cmd
);

    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_DIV      = 3'd1;
    localparam logic [2:0] S_DISP     = 3'd2;
    localparam logic [2:0] S_SCAN     = 3'd3;
    localparam logic [2:0] S_SCAN_OLD = 3'd4;
    localparam logic [2:0] S_FIND     = 3'd5;
    localparam logic [2:0] S_DONE     = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_in_ready = (r_state == S_IDLE);

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_DIV;
                end
            end
            S_DIV: begin
                if (i_stat.div_done) begin
                    o_cmd.probe_init = 1'b1;
                    n_state          = S_DISP;
                end else begin
                    o_cmd.div_step = 1'b1;
                end
            end
            S_DISP: begin
                case (i_stat.op)
                    lpht_pkg::OP_FIND: begin
                        n_state = S_FIND;
                    end
                    lpht_pkg::OP_INS_KEEP, lpht_pkg::OP_INS_REPLACE: begin
                        if (i_stat.full) begin
                            o_cmd.res_set      = 1'b1;
                            o_cmd.res_status   = lpht_pkg::ST_FULL;
                            o_cmd.res_pos_zero = 1'b1;
                            n_state            = S_DONE;
                        end else begin
                            n_state = S_SCAN;
                        end
                    end
                    default: begin
                        o_cmd.res_set      = 1'b1;
                        o_cmd.res_status   = lpht_pkg::ST_NOT_FOUND;
                        o_cmd.res_pos_zero = 1'b1;
                        n_state            = S_DONE;
                    end
                endcase
            end
            S_SCAN: begin
                if (i_stat.empty) begin
                    o_cmd.wr_new     = 1'b1;
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = lpht_pkg::ST_INSERTED;
                    n_state          = S_DONE;
                end else if (i_stat.op == lpht_pkg::OP_INS_REPLACE && i_stat.first) begin
                    // home taken: new entry goes home, old one moves on
                    o_cmd.swap      = 1'b1;
                    o_cmd.probe_adv = 1'b1;
                    n_state         = S_SCAN_OLD;
                end else begin
                    o_cmd.probe_adv = 1'b1;
                end
            end
            S_SCAN_OLD: begin
                if (i_stat.empty) begin
                    o_cmd.wr_old       = 1'b1;
                    o_cmd.res_set      = 1'b1;
                    o_cmd.res_status   = lpht_pkg::ST_INSERTED;
                    o_cmd.res_pos_home = 1'b1;
                    n_state            = S_DONE;
                end else begin
                    o_cmd.probe_adv = 1'b1;
                end
            end
            S_FIND: begin
                if (i_stat.hit) begin
                    o_cmd.res_set    = 1'b1;
                    o_cmd.res_status = lpht_pkg::ST_FOUND;
                    n_state          = S_DONE;
                end else if (i_stat.last) begin
                    o_cmd.res_set      = 1'b1;
                    o_cmd.res_status   = lpht_pkg::ST_NOT_FOUND;
                    o_cmd.res_pos_zero = 1'b1;
                    n_state            = S_DONE;
                end else begin
                    o_cmd.probe_adv = 1'b1;
                end
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: sv/lpht_dp.sv
// ----------------------------------------------------------------------------
// lpht_dp
// Datapath: size register, home-slot remainder unit, slot store, probe
// pointer and output register.
// ----------------------------------------------------------------------------
module lpht_dp (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  lpht_pkg::t_cmd                      i_cmd,
    output lpht_pkg::t_stat                     o_stat,
    input  logic [lpht_pkg::OP_W-1:0]           i_operation,
    input  logic [lpht_pkg::KEY_W-1:0]          i_hash_key,
    input  logic [lpht_pkg::WORD_W-1:0]         i_word,
    input  logic [lpht_pkg::WORD_W-1:0]         i_meaning_text,
    input  logic                                i_cfg_valid,
    input  logic [lpht_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_out_ready,
    output logic                                o_out_valid,
    output logic [lpht_pkg::ST_W-1:0]           o_out_status,
    output logic [lpht_pkg::POS_W-1:0]          o_out_pos
);

    localparam int DEPTH = lpht_pkg::TABLE_DEPTH;
    localparam int IDX_W = lpht_pkg::IDX_W;
    localparam int CNT_W = lpht_pkg::CNT_W;
    localparam int KEY_W = lpht_pkg::KEY_W;
    localparam int WORD_W = lpht_pkg::WORD_W;

    logic [lpht_pkg::CFG_W-1:0]     r_table_size;
    logic [CNT_W-1:0]               w_n;
    logic [DEPTH-1:0]               w_mask;

    logic [lpht_pkg::OP_W-1:0]      r_op;
    logic [WORD_W-1:0]              r_w;
    logic [WORD_W-1:0]              r_m;
    logic [KEY_W-1:0]               w_code;

    logic [KEY_W-1:0]               r_a;
    logic                           r_neg;
    logic [CNT_W-1:0]               r_rem;
    logic [lpht_pkg::DIV_CNT_W-1:0] r_div_cnt;
    logic [CNT_W:0]                 w_trial;
    logic [IDX_W-1:0]               w_home;

    logic [IDX_W-1:0]               r_p;
    logic [IDX_W-1:0]               r_home;
    logic [CNT_W-1:0]               r_k;
    logic [IDX_W-1:0]               w_p_next;
    logic [IDX_W-1:0]               w_p_sel;

    logic [DEPTH-1:0]               r_valid;
    logic [WORD_W-1:0]              r_word [DEPTH];
    logic [WORD_W-1:0]              r_word_rd;
    logic [WORD_W-1:0]              r_mean_mem [DEPTH];
    logic [WORD_W-1:0]              r_mean_rd;
    logic [WORD_W-1:0]              r_old_word;
    logic                           w_we;

    logic [lpht_pkg::ST_W-1:0]      r_res_status;
    logic [IDX_W-1:0]               r_res_pos;
    logic                           r_out_valid;
    logic [lpht_pkg::ST_W-1:0]      r_out_status;
    logic [lpht_pkg::POS_W-1:0]     r_out_pos;

    // ---- slot count in use
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_size <= lpht_pkg::SIZE_RESET;
        end else if (i_cfg_valid) begin
            r_table_size <= i_cfg_data;
        end
    end

    always_comb begin
        if (r_table_size == '0) begin
            w_n = CNT_W'(1);
        end else if (int'(r_table_size) > DEPTH) begin
            w_n = CNT_W'(DEPTH);
        end else begin
            w_n = CNT_W'(r_table_size);
        end
    end

    always_comb begin
        for (int i = 0; i < DEPTH; i++) begin
            w_mask[i] = (i < int'(w_n));
        end
    end

    // ---- item capture and home-slot remainder, one dividend bit a cycle
    assign w_code  = (i_operation == lpht_pkg::OP_FIND) ? i_word[KEY_W-1:0] : i_hash_key;
    assign w_trial = {r_rem, r_a[KEY_W-1]};

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op      <= i_operation;
            r_w       <= i_word;
            r_m       <= i_meaning_text;
            r_neg     <= (w_code < lpht_pkg::HOME_OFFSET);
            r_a       <= (w_code < lpht_pkg::HOME_OFFSET) ? lpht_pkg::HOME_OFFSET - w_code
                                                          : w_code - lpht_pkg::HOME_OFFSET;
            r_rem     <= '0;
            r_div_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_a       <= {r_a[KEY_W-2:0], 1'b0};
            r_div_cnt <= r_div_cnt + 1'b1;
            if (w_trial >= {1'b0, w_n}) begin
                r_rem <= CNT_W'(w_trial - {1'b0, w_n});
            end else begin
                r_rem <= CNT_W'(w_trial);
            end
        end
    end

    // negative offsets fold back into 0..n-1
    assign w_home = (r_neg && r_rem != '0) ? IDX_W'(w_n - r_rem) : IDX_W'(r_rem);

    // ---- probe pointer, wraps at the slot count
    assign w_p_next = (CNT_W'(r_p) == w_n - CNT_W'(1)) ? '0 : r_p + 1'b1;

    // slot the pointer holds after this edge; the word read follows it
    assign w_p_sel = i_cmd.probe_init ? w_home : (i_cmd.probe_adv ? w_p_next : r_p);

    always_ff @(posedge i_clk) begin
        if (i_cmd.probe_init) begin
            r_p    <= w_home;
            r_home <= w_home;
            r_k    <= '0;
        end else if (i_cmd.probe_adv) begin
            r_p <= w_p_next;
            r_k <= r_k + 1'b1;
        end
    end

    // ---- slot store
    assign w_we = i_cmd.wr_new | i_cmd.wr_old | i_cmd.swap;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (w_we) begin
            r_valid[r_p] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_word[r_p] <= i_cmd.wr_old ? r_old_word : r_w;
        end
        r_word_rd <= r_word[w_p_sel];
        if (i_cmd.swap) begin
            r_old_word <= r_word_rd;
        end
    end

    // meaning memory: read returns the entry as it was before a same-cycle write
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mean_mem[r_p] <= i_cmd.wr_old ? r_mean_rd : r_m;
        end
        if (i_cmd.swap) begin
            r_mean_rd <= r_mean_mem[r_p];
        end
    end

    // ---- result and output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.res_set) begin
            r_res_status <= i_cmd.res_status;
            if (i_cmd.res_pos_zero) begin
                r_res_pos <= '0;
            end else if (i_cmd.res_pos_home) begin
                r_res_pos <= r_home;
            end else begin
                r_res_pos <= r_p;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_status <= r_res_status;
            r_out_pos    <= lpht_pkg::POS_W'(r_res_pos);
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_out_status = r_out_status;
    assign o_out_pos    = r_out_pos;

    // ---- status to the sequencer
    always_comb begin
        o_stat          = '0;
        o_stat.op       = r_op;
        o_stat.div_done = (r_div_cnt == lpht_pkg::DIV_CNT_W'(KEY_W));
        o_stat.full     = &(r_valid | ~w_mask);
        o_stat.empty    = !r_valid[r_p];
        o_stat.hit      = r_valid[r_p] && (r_word_rd == r_w);
        o_stat.first    = (r_k == '0);
        o_stat.last     = (r_k == w_n - CNT_W'(1));
        o_stat.out_free = !r_out_valid || i_out_ready;
    end

endmodule

// File: sv/lpht_checker.sv
// ----------------------------------------------------------------------------
// lpht_checker
// Port-level checks of the hash table, bound to the top level.
// ----------------------------------------------------------------------------
`include "linear_probe_hash_table_defines.svh"

module lpht_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_axis_tvalid,
    input logic         i_s_axis_tready,
    input logic         i_m_axis_tvalid,
    input logic         i_m_axis_tready,
    input logic [7:0]   i_m_axis_tdata,
    input logic [1:0]   i_m_axis_tuser
);

    // a held result beat keeps its payload
    `LPHT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_m_axis_tvalid && !i_m_axis_tready, i_m_axis_tvalid && $stable(i_m_axis_tdata) && $stable(i_m_axis_tuser), "result beat changed while stalled")

    // full and not-found results carry slot zero
    `LPHT_ASSERT_IMPL(a_pos_zero, i_clk, i_rst_n, i_m_axis_tvalid && (i_m_axis_tuser == lpht_pkg::ST_FULL || i_m_axis_tuser == lpht_pkg::ST_NOT_FOUND), i_m_axis_tdata == 8'd0, "non-zero slot on a miss or full result")

    // one operation at a time: busy right after an input beat
    `LPHT_ASSERT_NEXT(a_busy_after_in, i_clk, i_rst_n, i_s_axis_tvalid && i_s_axis_tready, !i_s_axis_tready, "input taken again straight after a beat")

    // a result does not appear straight after its input beat
    `LPHT_ASSERT_NEXT(a_no_early_out, i_clk, i_rst_n, i_s_axis_tvalid && i_s_axis_tready && !i_m_axis_tvalid, !i_m_axis_tvalid, "result appeared too soon after its input")

endmodule

bind linear_probe_hash_table lpht_checker u_lpht_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .i_s_axis_tready (o_s_axis_tready),
    .i_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .i_m_axis_tdata  (o_m_axis_tdata),
    .i_m_axis_tuser  (o_m_axis_tuser)
);

// File: dv/tb_linear_probe_hash_table.sv
// ----------------------------------------------------------------------------
// tb_linear_probe_hash_table
// Self-checking bench for the linear-probe word/meaning dictionary: a queue
// fed driver streams insert, find and unused operations, a monitor mirrors
// the table contents and the slot count, and every result beat is compared
// with the status and slot that the mirror predicts. The slot count is
// rewritten between phases, from zero (one slot) to beyond the full depth.
// ----------------------------------------------------------------------------
module tb_linear_probe_hash_table;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [lpht_pkg::OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int RX_HOLD_CYCLES = 400;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int PHASE_OPS      = 92;
    localparam int DEPTH          = lpht_pkg::TABLE_DEPTH;
    localparam int WORD_W         = lpht_pkg::WORD_W;

    typedef struct packed {
        logic [lpht_pkg::OP_W-1:0]  op;
        logic [lpht_pkg::KEY_W-1:0] key;
        logic [WORD_W-1:0]          word;
        logic [WORD_W-1:0]          text;
    } t_dict_op;

    typedef struct packed {
        logic [lpht_pkg::ST_W-1:0]  status;
        logic [lpht_pkg::POS_W-1:0] slot;
    } t_dict_reply;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [135:0] i_s_axis_tdata = '0;  // hash_key[7:0], word[71:8], meaning_text[135:72]
    logic [1:0]   i_s_axis_tuser = '0;  // operation[1:0]
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [7:0]   o_m_axis_tdata;       // position[4:0], zero fill [7:5]
    logic [1:0]   o_m_axis_tuser;       // status[1:0]
    logic         i_cfg_valid = 1'b0;
    logic         o_cfg_ready;
    logic [5:0]   i_cfg_data = '0;

    linear_probe_hash_table dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Mirror of the table
    logic [lpht_pkg::CFG_W-1:0] table_size_q = lpht_pkg::SIZE_RESET;
    bit                slot_live   [DEPTH];
    logic [WORD_W-1:0] slot_word_q [DEPTH];
    logic [WORD_W-1:0] slot_text_q [DEPTH];

    t_dict_op          op_backlog[$];
    t_dict_reply       reply_q[$];
    logic [WORD_W-1:0] known_words[$];

    int  ops_queued     = 0;
    int  ops_taken      = 0;
    int  size_writes    = 0;
    int  mismatches     = 0;
    int  quiet_cycles   = 0;
    int  tx_idle_pct    = 26;
    int  rx_idle_pct    = 83;
    int  rx_hold_req    = 0;
    int  rx_hold_ack    = 0;
    int  rx_hold_left   = 0;
    bit  in_beat_taken  = 1'b0;

    function automatic int home_of(logic [7:0] code, int n);
        int h;
        h = (int'(code) - int'(lpht_pkg::HOME_OFFSET)) % n;
        if (h < 0)
            h += n;
        return h;
    endfunction

    function automatic int next_free(int start, int n);
        int p;
        p = start % n;
        for (int k = 0; k < n; k++) begin
            if (!slot_live[p])
                return p;
            p = (p + 1) % n;
        end
        return start % n;
    endfunction

    function automatic void put_entry(int slot, logic [WORD_W-1:0] w, logic [WORD_W-1:0] m);
        slot_live[slot]   = 1'b1;
        slot_word_q[slot] = w;
        slot_text_q[slot] = m;
    endfunction

    function automatic t_dict_reply apply_dict_op(t_dict_op it);
        int                n;
        int                h;
        int                p;
        bit                full;
        logic [WORD_W-1:0] old_w;
        logic [WORD_W-1:0] old_m;
        t_dict_reply       r;
        if (table_size_q == 0)
            n = 1;
        else if (table_size_q > DEPTH)
            n = DEPTH;
        else
            n = int'(table_size_q);
        r.status = lpht_pkg::ST_NOT_FOUND;
        r.slot   = '0;
        if (it.op == lpht_pkg::OP_INS_KEEP || it.op == lpht_pkg::OP_INS_REPLACE) begin
            full = 1'b1;
            for (int k = 0; k < n; k++)
                if (!slot_live[k])
                    full = 1'b0;
            if (full) begin
                r.status = lpht_pkg::ST_FULL;
            end else begin
                h = home_of(it.key, n);
                if (it.op == lpht_pkg::OP_INS_KEEP || !slot_live[h]) begin
                    p = next_free(h, n);
                    put_entry(p, it.word, it.text);
                    r.slot = lpht_pkg::POS_W'(p);
                end else begin
                    // displace the resident entry to the next free slot after home
                    old_w = slot_word_q[h];
                    old_m = slot_text_q[h];
                    put_entry(h, it.word, it.text);
                    p = next_free((h + 1) % n, n);
                    put_entry(p, old_w, old_m);
                    r.slot = lpht_pkg::POS_W'(h);
                end
                r.status = lpht_pkg::ST_INSERTED;
            end
        end else if (it.op == lpht_pkg::OP_FIND) begin
            p = home_of(it.word[7:0], n);
            for (int k = 0; k < n; k++) begin
                if (slot_live[p] && slot_word_q[p] == it.word) begin
                    r.status = lpht_pkg::ST_FOUND;
                    r.slot   = lpht_pkg::POS_W'(p);
                    break;
                end
                p = (p + 1) % n;
            end
        end
        return r;
    endfunction

    task automatic note_mismatch(string what, int unsigned exp_v, int unsigned act_v);
        mismatches++;
        if (mismatches <= 10)
            $display("[%0t] %s mismatch: expected %0h, got %0h", $realtime, what, exp_v, act_v);
    endtask

    // Send side: hold the beat until taken, then advance or idle
    always @(negedge i_clk) begin : drive_ops
        t_dict_op nxt;
        if (!i_rst_n) begin
            i_s_axis_tvalid <= 1'b0;
        end else if (!i_s_axis_tvalid || in_beat_taken) begin
            if (op_backlog.size() > 0 && $urandom_range(0, 99) >= tx_idle_pct) begin
                nxt = op_backlog.pop_front();
                i_s_axis_tdata  <= {nxt.text, nxt.word, nxt.key};
                i_s_axis_tuser  <= nxt.op;
                i_s_axis_tvalid <= 1'b1;
            end else begin
                i_s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Receive side: random back-pressure plus an occasional long hold-off
    always @(negedge i_clk) begin
        if (rx_hold_req != rx_hold_ack) begin
            rx_hold_ack  = rx_hold_req;
            rx_hold_left = RX_HOLD_CYCLES;
        end
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (rx_hold_left > 0) begin
            rx_hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin : watch_bus
        t_dict_op    seen;
        t_dict_reply want;
        bit          busy;
        busy = 1'b0;
        in_beat_taken = 1'b0;
        if (i_rst_n) begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                busy = 1'b1;
                if (reply_q.size() == 0) begin
                    note_mismatch("unexpected result beat, tdata", 0, o_m_axis_tdata);
                end else begin
                    want = reply_q.pop_front();
                    if (o_m_axis_tuser !== want.status)
                        note_mismatch("status", want.status, o_m_axis_tuser);
                    if (o_m_axis_tdata !== {3'b000, want.slot})
                        note_mismatch("position", want.slot, o_m_axis_tdata);
                end
            end
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                busy = 1'b1;
                in_beat_taken = 1'b1;
                seen.op   = i_s_axis_tuser;
                seen.key  = i_s_axis_tdata[7:0];
                seen.word = i_s_axis_tdata[71:8];
                seen.text = i_s_axis_tdata[135:72];
                reply_q.push_back(apply_dict_op(seen));
                ops_taken++;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                busy = 1'b1;
                table_size_q = i_cfg_data;
                size_writes++;
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic push_op(logic [lpht_pkg::OP_W-1:0] op, logic [7:0] key,
                           logic [WORD_W-1:0] w, logic [WORD_W-1:0] m);
        t_dict_op it;
        it.op   = op;
        it.key  = key;
        it.word = w;
        it.text = m;
        if (op == lpht_pkg::OP_INS_KEEP || op == lpht_pkg::OP_INS_REPLACE)
            known_words.push_back(w);
        op_backlog.push_back(it);
        ops_queued++;
    endtask

    task automatic wait_idle();
        wait (ops_taken == ops_queued && reply_q.size() == 0);
    endtask

    task automatic write_size(logic [lpht_pkg::CFG_W-1:0] value);
        int target;
        target = size_writes + 1;
        @(negedge i_clk);
        i_cfg_data  <= value;
        i_cfg_valid <= 1'b1;
        wait (size_writes == target);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Word whose first letter is the given code, the rest lower-case
    function automatic logic [WORD_W-1:0] make_word(logic [7:0] first);
        logic [WORD_W-1:0] w;
        int                len;
        len = $urandom_range(1, 8);
        w = '0;
        w[7:0] = first;
        for (int i = 1; i < len; i++)
            w[i*8 +: 8] = 8'(97 + $urandom_range(0, 25));
        return w;
    endfunction

    task automatic random_op();
        int                pick;
        logic [7:0]        key;
        logic [WORD_W-1:0] w;
        logic [WORD_W-1:0] m;
        pick = $urandom_range(0, 99);
        m = {$urandom, $urandom};
        if (pick < 30) begin
            key = 8'($urandom_range(97, 140));
            push_op($urandom_range(0, 1) ? lpht_pkg::OP_INS_REPLACE : lpht_pkg::OP_INS_KEEP,
                    key, make_word(key), m);
        end else if (pick < 75) begin
            if (known_words.size() > 0)
                w = known_words[$urandom_range(0, known_words.size() - 1)];
            else
                w = make_word(8'($urandom_range(97, 122)));
            push_op(lpht_pkg::OP_FIND, 8'($urandom), w, m);
        end else if (pick < 85) begin
            push_op(lpht_pkg::OP_FIND, 8'($urandom), make_word(8'($urandom_range(97, 122))), m);
        end else if (pick < 95) begin
            push_op(2'($urandom_range(0, 3)), 8'($urandom), {$urandom, $urandom}, m);
        end else begin
            push_op(OP_UNUSED, 8'($urandom), {$urandom, $urandom}, m);
        end
    endtask

    localparam logic [WORD_W-1:0] W_ONE   = 64'h0000_0000_0073_6361;
    localparam logic [WORD_W-1:0] W_TWO   = 64'h0000_0000_656c_7061;
    localparam logic [WORD_W-1:0] W_THREE = 64'h0000_6e6f_6863_6e61;

    initial begin
        logic [lpht_pkg::CFG_W-1:0] phase_size [14];
        phase_size = '{6'd0, 6'd1, 6'd2, 6'd3, 6'd4, 6'd6, 6'd8, 6'd12, 6'd17,
                       6'd24, 6'd31, 6'd63, 6'd5, 6'd32};

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, probing, displacement, wrap-round, odd codes
        push_op(lpht_pkg::OP_FIND,        8'h61, 64'h61, '0);
        push_op(lpht_pkg::OP_INS_KEEP,    8'h61, W_ONE, '1);
        push_op(lpht_pkg::OP_INS_KEEP,    8'h61, W_TWO, 64'h0123_4567_89ab_cdef);
        push_op(lpht_pkg::OP_INS_REPLACE, 8'h61, W_THREE, 64'hfedc_ba98_7654_3210);
        push_op(lpht_pkg::OP_FIND,        8'h00, W_ONE, '0);
        push_op(lpht_pkg::OP_FIND,        8'h00, W_THREE, '0);
        push_op(lpht_pkg::OP_INS_KEEP,    8'h00, '0, '0);
        push_op(lpht_pkg::OP_INS_KEEP,    8'hff, '1, '0);
        push_op(lpht_pkg::OP_INS_KEEP,    8'h60, 64'h0000_0000_0000_7760, '1);
        push_op(lpht_pkg::OP_INS_REPLACE, 8'h7a, 64'h0000_0000_0061_727a,
                64'h5555_5555_5555_5555);
        push_op(lpht_pkg::OP_FIND,        8'hff, '0, '1);
        push_op(lpht_pkg::OP_FIND,        8'h00, '1, '0);
        push_op(lpht_pkg::OP_FIND,        8'h61, W_TWO, '0);
        push_op(lpht_pkg::OP_FIND,        8'h61, 64'h0000_0000_0000_7861, '0);
        push_op(OP_UNUSED,                8'haa, 64'h5555_5555_5555_5555,
                64'haaaa_aaaa_aaaa_aaaa);
        push_op(lpht_pkg::OP_INS_REPLACE, 8'h7f, 64'h0000_0000_0000_7f7f, '1);
        push_op(lpht_pkg::OP_FIND,        8'h55, '1, '0);
        push_op(lpht_pkg::OP_INS_KEEP,    8'h80, 64'h5555_5555_5555_5555,
                64'haaaa_aaaa_aaaa_aaaa);
        push_op(lpht_pkg::OP_FIND,        8'h80, 64'haaaa_aaaa_aaaa_aaaa, '0);
        wait_idle();

        for (int ph = 0; ph < 14; ph++) begin
            if (ph < 5) begin
                tx_idle_pct = 26;
                rx_idle_pct = 83;
            end else if (ph < 10) begin
                tx_idle_pct = 83;
                rx_idle_pct = 26;
            end else begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            write_size(phase_size[ph]);
            for (int i = 0; i < PHASE_OPS; i++)
                random_op();
            // back up the result side while the sender keeps offering
            if (ph == 2 || ph == 11) begin
                @(posedge i_clk);
                rx_hold_req++;
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// File: linear_probe_hash_table.f
+incdir+sv
sv/lpht_pkg.sv
sv/lpht_ctrl.sv
sv/lpht_dp.sv
sv/linear_probe_hash_table.sv
sv/lpht_checker.sv
dv/tb_linear_probe_hash_table.sv
